FILE: design/bfdh_pkg.sv
// Shared types and constants for the double-hash bloom filter.
package bfdh_pkg;

  typedef logic [63:0] hash_t;

  localparam hash_t DJB_SEED  = 64'd5381;
  localparam hash_t SDBM_SEED = 64'd0;

  localparam int CFG_W      = 17;
  localparam int FILTER_RST = 65536;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // status of the remainder unit as seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

endpackage

FILE: design/bfdh_hash.sv
// Running djb2 and sdbm hashes over the key bytes.
module bfdh_hash (
  input  logic           clk,
  input  logic           rst,
  input  logic           beat,
  input  logic           last,
  input  logic [7:0]     key_byte,
  output bfdh_pkg::hash_t djb_next,
  output bfdh_pkg::hash_t sdbm_next
);

  bfdh_pkg::hash_t djb;
  bfdh_pkg::hash_t sdbm;
  logic            key_ended;
  logic            take;

  assign take = !key_ended && (key_byte != 8'd0);

  always_comb begin
    djb_next  = djb;
    sdbm_next = sdbm;
    if (take) begin
      djb_next  = (djb << 5) + djb + {56'd0, key_byte};
      sdbm_next = {56'd0, key_byte} + (sdbm << 6) + (sdbm << 16) - sdbm;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      djb       <= bfdh_pkg::DJB_SEED;
      sdbm      <= bfdh_pkg::SDBM_SEED;
      key_ended <= 1'b0;
    end else if (beat) begin
      if (last) begin
        djb       <= bfdh_pkg::DJB_SEED;
        sdbm      <= bfdh_pkg::SDBM_SEED;
        key_ended <= 1'b0;
      end else begin
        djb  <= djb_next;
        sdbm <= sdbm_next;
        if (key_byte == 8'd0) key_ended <= 1'b1;
      end
    end
  end

endmodule

FILE: design/bfdh_mod.sv
// Restoring remainder unit: 64-bit value modulo the filter size, one bit a cycle.
module bfdh_mod #(
  parameter int NB = 17
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  bfdh_pkg::hash_t       dividend,
  input  logic [NB-1:0]         divisor,
  output bfdh_pkg::mod_status_t status,
  output logic [NB-1:0]         remainder
);

  bfdh_pkg::hash_t shreg;
  logic [NB-1:0]   rem;
  logic [5:0]      count;
  logic            busy;
  logic            done;
  logic [NB:0]     trial;
  logic [NB:0]     trial_sub;

  assign trial     = {rem, shreg[63]};
  assign trial_sub = trial - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= dividend;
      rem   <= '0;
      count <= 6'd0;
    end else if (busy) begin
      shreg <= shreg << 1;
      count <= count + 6'd1;
      if (trial >= {1'b0, divisor}) rem <= trial_sub[NB-1:0];
      else                          rem <= trial[NB-1:0];
    end
  end

  assign status    = '{busy: busy, done: done};
  assign remainder = rem;

endmodule

FILE: design/bloom_filter_double_hash.sv
// Bloom filter top level: key hashing, probe sequencer and bit store.
// Key bytes are taken one a cycle while the sequencer is idle. The beat marked
// last starts NUM_HASHES probes; each probe runs the bit-serial remainder unit,
// then the bit store read and the check with its update (a search stops at the
// first clear bit). After reset a clearing pass zeroes the store before any
// beat is taken; filter_bits writes are taken at any time.
module bloom_filter_double_hash #(
  parameter int NUM_HASHES = 16,
  parameter int MAX_BITS   = 65536
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [bfdh_pkg::CFG_W-1:0]  cfg_wdata,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [7:0]                  s_tdata,   // key_byte
  input  logic                        s_tuser,   // mode
  input  logic                        s_tlast,   // last_byte
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [7:0]                  m_tdata,   // present, zero padded
  output logic                        m_tuser    // was_search
);

  localparam int NB    = $clog2(MAX_BITS + 1);
  localparam int DEPTH = (MAX_BITS + 7) / 8;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int BW    = (NB > AW + 3) ? NB : AW + 3;
  localparam int CW    = (NB > bfdh_pkg::CFG_W) ? NB : bfdh_pkg::CFG_W;
  localparam int KW    = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_RD    = 3'd3;
  localparam logic [2:0] ST_CHK   = 3'd4;

  logic [2:0]                 state;
  logic [bfdh_pkg::CFG_W-1:0] filter_bits;
  logic [AW-1:0]              clr_addr;
  bfdh_pkg::hash_t            djb_next, sdbm_next;
  bfdh_pkg::hash_t            probe_h, step;
  logic [KW-1:0]              probe_ix;
  logic                       mode_q;
  logic                       all_set;
  logic [NB-1:0]              n_eff;
  logic [CW-1:0]              fb_wide;
  logic                       mod_start;
  bfdh_pkg::hash_t            mod_arg;
  bfdh_pkg::mod_status_t      mod_st;
  logic [NB-1:0]              mod_rem;
  logic [BW-1:0]              bidx;
  logic [AW-1:0]              addr;
  logic [2:0]                 bit_sel;
  logic [7:0]                 store [DEPTH];
  logic [7:0]                 rdata;
  logic                       beat;
  logic                       last_beat;
  logic                       probe_hit;
  logic                       finish;

  assign s_tready  = (state == ST_IDLE) && !(s_tlast && m_tvalid);
  assign beat      = s_tvalid && s_tready;
  assign last_beat = beat && s_tlast;

  always_ff @(posedge clk) begin
    if (rst) filter_bits <= bfdh_pkg::CFG_W'(bfdh_pkg::FILTER_RST);
    else if (cfg_we) filter_bits <= cfg_wdata;
  end

  // zero means one bit, anything above the store size saturates
  assign fb_wide = CW'(filter_bits);
  always_comb begin
    priority if (filter_bits == '0)        n_eff = NB'(1);
    else if (fb_wide > CW'(MAX_BITS))      n_eff = NB'(MAX_BITS);
    else                                   n_eff = fb_wide[NB-1:0];
  end

  bfdh_hash u_hash (
    .clk      (clk),
    .rst      (rst),
    .beat     (beat),
    .last     (s_tlast),
    .key_byte (s_tdata),
    .djb_next (djb_next),
    .sdbm_next(sdbm_next)
  );

  assign probe_hit = rdata[bit_sel];
  assign finish    = (state == ST_CHK) &&
                     ((probe_ix == KW'(NUM_HASHES - 1)) ||
                      (mode_q == bfdh_pkg::MODE_SEARCH && !probe_hit));

  assign mod_start = last_beat || ((state == ST_CHK) && !finish);
  assign mod_arg   = last_beat ? djb_next : probe_h + step;

  bfdh_mod #(.NB(NB)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (mod_start),
    .dividend (mod_arg),
    .divisor  (n_eff),
    .status   (mod_st),
    .remainder(mod_rem)
  );

  assign bidx = BW'(mod_rem);

  always_ff @(posedge clk) begin
    if (mod_st.done) begin
      addr    <= bidx[AW+2:3];
      bit_sel <= bidx[2:0];
    end
  end

  // bit store: one read or one write per cycle
  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      store[clr_addr] <= 8'd0;
    end else if (state == ST_CHK && mode_q == bfdh_pkg::MODE_INSERT) begin
      store[addr] <= rdata | (8'd1 << bit_sel);
    end
    if (state == ST_RD) rdata <= store[addr];
  end

  always_ff @(posedge clk) begin
    if (last_beat) begin
      probe_h  <= djb_next;
      step     <= sdbm_next + 64'd1;
      probe_ix <= '0;
      mode_q   <= s_tuser;
      all_set  <= 1'b1;
    end else if (state == ST_CHK) begin
      if (!probe_hit) all_set <= 1'b0;
      probe_h  <= probe_h + step;
      step     <= step + 64'd2;
      probe_ix <= probe_ix + KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: if (last_beat) state <= ST_DIV;
        ST_DIV:  if (mod_st.done) state <= ST_RD;
        ST_RD:   state <= ST_CHK;
        ST_CHK: begin
          if (finish) begin
            state    <= ST_IDLE;
            m_tvalid <= 1'b1;
          end else begin
            state <= ST_DIV;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tuser <= mode_q;
      m_tdata <= {7'd0, (mode_q == bfdh_pkg::MODE_SEARCH) && all_set && probe_hit};
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> (state == ST_IDLE))
    else $error("input taken outside idle");

  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    last_beat |=> (state == ST_DIV && mod_st.busy))
    else $error("probe did not start");

  a_chk_after_rd: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CHK) |-> $past(state) == ST_RD)
    else $error("check without read");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (finish && m_tvalid) |-> m_tready)
    else $error("result overwritten");

endmodule

FILE: test/testbench.sv
// Testbench for the double-hash bloom filter: scoreboard, drivers and checks.
class bloom_scoreboard;
  logic [63:0] djb;
  logic [63:0] sdbm;
  bit          key_ended;
  bit          bits [0:65535];
  int          filter_bits;
  bit          exp_search [$];
  bit          exp_present [$];
  int          errors;

  function new();
    djb = 64'd5381;
    sdbm = 64'd0;
    key_ended = 0;
    foreach (bits[i]) bits[i] = 0;
    filter_bits = 65536;
    errors = 0;
  endfunction

  function void set_size(int v);
    filter_bits = v;
  endfunction

  // takes one accepted key beat
  function void note_beat(bit mode, logic [7:0] kb, bit last);
    logic [63:0] n;
    logic [63:0] h;
    logic [63:0] ix;
    bit all_set;
    all_set = 1;
    if (!key_ended) begin
      if (kb == 8'd0) key_ended = 1;
      else begin
        djb = (djb << 5) + djb + {56'd0, kb};
        sdbm = {56'd0, kb} + (sdbm << 6) + (sdbm << 16) - sdbm;
      end
    end
    if (!last) return;
    n = filter_bits;
    if (n == 0) n = 1;
    if (n > 65536) n = 65536;
    for (int i = 0; i < 16; i++) begin
      h = djb + 64'(i) * sdbm + 64'(i * i);
      ix = h % n;
      if (mode == bfdh_pkg::MODE_INSERT) bits[ix[15:0]] = 1;
      else if (!bits[ix[15:0]]) begin
        all_set = 0;
        break;
      end
    end
    exp_search.push_back(mode);
    exp_present.push_back(mode == bfdh_pkg::MODE_SEARCH && all_set);
    djb = 64'd5381;
    sdbm = 64'd0;
    key_ended = 0;
  endfunction

  function void check_result(logic was_search, logic [7:0] data);
    bit es, ep;
    if (exp_search.size() == 0) begin
      $error("unexpected result beat");
      errors++;
      return;
    end
    es = exp_search.pop_front();
    ep = exp_present.pop_front();
    if (was_search !== es) begin
      $error("was_search expected %0d actual %0d", es, was_search);
      errors++;
    end
    if (data !== {7'd0, ep}) begin
      $error("present expected %0d actual %0d", ep, data);
      errors++;
    end
  endfunction
endclass

module testbench;
  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [bfdh_pkg::CFG_W-1:0] cfg_wdata = '0;
  logic s_tvalid = 0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [7:0] m_tdata;
  logic m_tuser;

  bloom_scoreboard sb = new();
  bit calm = 0;
  bit hold_rx = 0;

  always #5 clk = ~clk;

  bloom_filter_double_hash u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // receiver with random stalls and an optional long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) sb.check_result(m_tuser, m_tdata);
      m_tready <= !hold_rx && (calm || $urandom_range(99) >= 9);
    end
  end

  // valid stays high between beats unless an idle gap is taken
  task automatic send_beat(bit mode, logic [7:0] kb, bit last);
    if (!calm && $urandom_range(99) < 9) begin
      s_tvalid <= 0;
      @(posedge clk);
      while (!calm && $urandom_range(99) < 9) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tdata <= kb;
    s_tuser <= mode;
    s_tlast <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_beat(mode, kb, last);
  endtask

  task automatic send_key(bit mode, logic [7:0] k[$]);
    for (int i = 0; i < k.size(); i++)
      send_beat(mode, k[i], i == k.size() - 1);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.exp_search.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_size(int v);
    drain();
    cfg_we <= 1;
    cfg_wdata <= bfdh_pkg::CFG_W'(v);
    sb.set_size(v);
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  // random key of mostly printable bytes, sometimes with an early terminator
  task automatic random_key(output logic [7:0] k[$]);
    int len;
    k = {};
    len = $urandom_range(1, 6);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(19) == 0) k.push_back(8'd0);
      else if ($urandom_range(3) == 0) k.push_back(8'($urandom_range(1, 255)));
      else k.push_back(8'($urandom_range(97, 100)));
    end
  endtask

  task automatic random_phase(int nbeats);
    logic [7:0] k[$];
    logic [7:0] saved[$];
    int sent;
    sent = 0;
    while (sent < nbeats) begin
      // reuse the previous key now and then so searches can hit
      if (saved.size() != 0 && $urandom_range(1)) k = saved;
      else random_key(k);
      saved = k;
      send_key(1'($urandom_range(1)), k);
      sent += k.size();
    end
  endtask

  initial begin
    logic [7:0] k[$];
    repeat (5) @(posedge clk);
    rst <= 0;
    // directed part
    k = {8'd0}; send_key(bfdh_pkg::MODE_SEARCH, k);
    send_key(bfdh_pkg::MODE_INSERT, k);
    send_key(bfdh_pkg::MODE_SEARCH, k);
    k = {8'hff, 8'h01, 8'h80}; send_key(bfdh_pkg::MODE_SEARCH, k);
    send_key(bfdh_pkg::MODE_INSERT, k);
    send_key(bfdh_pkg::MODE_SEARCH, k);
    k = {8'h41, 8'h00, 8'h7f, 8'hff}; send_key(bfdh_pkg::MODE_INSERT, k);
    k = {8'h41, 8'h00}; send_key(bfdh_pkg::MODE_SEARCH, k);
    k = {8'h55, 8'haa, 8'h00}; send_key(bfdh_pkg::MODE_SEARCH, k);
    write_size(0);
    k = {8'h12}; send_key(bfdh_pkg::MODE_SEARCH, k);
    send_key(bfdh_pkg::MODE_INSERT, k);
    k = {8'h34}; send_key(bfdh_pkg::MODE_SEARCH, k);
    write_size(1);
    send_key(bfdh_pkg::MODE_SEARCH, k);
    write_size(131071);
    k = {8'h66, 8'h99}; send_key(bfdh_pkg::MODE_SEARCH, k);
    send_key(bfdh_pkg::MODE_INSERT, k);
    send_key(bfdh_pkg::MODE_SEARCH, k);
    // random phases across sizes
    write_size(37);
    random_phase(400);
    write_size(65536);
    calm = 1;
    random_phase(200);
    calm = 0;
    // long receiver hold-off while keys keep coming
    hold_rx = 1;
    fork
      begin
        repeat (3000) @(posedge clk);
        hold_rx = 0;
      end
      begin
        random_phase(60);
        s_tvalid <= 0;
        @(posedge clk);
      end
    join
    drain();
    write_size(1000);
    random_phase(500);
    write_size(8);
    random_phase(300);
    write_size($urandom_range(2, 131071));
    random_phase(540);
    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.exp_search.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #200000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
